@@ rtl/core/uer_pkg.sv @@
// Shared package of the ultrasonic echo ranger: register indexes, reset values,
// result codes and the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package uer_pkg;

   localparam int TICK_BITS_DEF = 24;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   localparam int PHASE_W    = 10;
   localparam int TIMEOUT_W  = 24;
   localparam int DIVISOR_W  = 16;
   localparam int DIST_W     = 16;
   localparam int ATTEMPT_W  = 8;
   localparam int STATUS_W   = 2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_PRE_LOW   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRIGGER   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TICKS_CM  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_RANGE = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_RETRY     = 3'd5;

   // register reset values
   localparam logic [PHASE_W-1:0]   PRE_LOW_RST   = 10'd10;
   localparam logic [PHASE_W-1:0]   TRIGGER_RST   = 10'd15;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST   = 24'd30000;
   localparam logic [DIVISOR_W-1:0] TICKS_CM_RST  = 16'd58;
   localparam logic [DIST_W-1:0]    MAX_RANGE_RST = 16'd400;
   localparam logic [ATTEMPT_W-1:0] RETRY_RST     = 8'd6;

   localparam logic [DIST_W-1:0] DIST_SAT = 16'hFFFF;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK          = 2'd0,
      STAT_TIMEOUT     = 2'd1,
      STAT_NO_OBSTACLE = 2'd2
   } status_type;

   typedef struct packed {
      logic       attempt_clr;   // clear phase, wait and pulse counters
      logic       load_attempts;
      logic       dec_attempts;
      logic       phase_inc;
      logic       phase_clr;
      logic       wait_count;
      logic       pulse_inc;
      logic       div_start;
      logic       rsp_load;
      logic       rsp_trig;
      logic       rsp_busy;
      logic       rsp_done;
      logic       rsp_use_quot;
      status_type rsp_status;
   } cmd_type;

   typedef struct packed {
      logic pre_low_zero;
      logic pre_low_hit;
      logic trig_hit;
      logic wait_over;
      logic attempts_zero;
      logic div_done;
      logic dist_over;
   } sts_type;

endpackage

@@ rtl/core/uer_chan_if.sv @@
// Valid/ready channel interfaces of the ultrasonic echo ranger: tick transactions
// in, result transactions out. Depends on uer_pkg.
`timescale 1ns / 1ps

interface uer_req_if;
   logic valid;
   logic ready;
   logic start_req;
   logic echo_level;

   modport source (output valid, output start_req, output echo_level, input ready);
   modport sink   (input valid, input start_req, input echo_level, output ready);
endinterface

interface uer_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       trig_level;
   logic                       busy_res;
   logic                       done_res;
   logic [uer_pkg::DIST_W-1:0]   distance_cm;
   logic [uer_pkg::STATUS_W-1:0] status;

   modport source (output valid, output trig_level, output busy_res, output done_res,
                   output distance_cm, output status, input ready);
   modport sink   (input valid, input trig_level, input busy_res, input done_res,
                   input distance_cm, input status, output ready);
endinterface

@@ rtl/core/uer_datapath.sv @@
// Datapath of the ultrasonic echo ranger: configuration registers, tick counters,
// bit-serial divider and result register. Depends on uer_pkg.
`timescale 1ns / 1ps

module uer_datapath #(
   parameter int TICK_BITS = uer_pkg::TICK_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [uer_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [uer_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  uer_pkg::cmd_type               cmd,
   output uer_pkg::sts_type               sts,
   output logic                           rsp_trig_level,
   output logic                           rsp_busy_res,
   output logic                           rsp_done_res,
   output logic [uer_pkg::DIST_W-1:0]      rsp_distance_cm,
   output logic [uer_pkg::STATUS_W-1:0]    rsp_status
);

   localparam int CNT_W = $clog2(TICK_BITS + 1);
   localparam int CMP_W = (TICK_BITS + 1 > uer_pkg::TIMEOUT_W) ? TICK_BITS + 1
                                                                 : uer_pkg::TIMEOUT_W;
   localparam int DV_W  = uer_pkg::DIVISOR_W;

   // configuration
   logic [uer_pkg::PHASE_W-1:0]   pre_low_ff;
   logic [uer_pkg::PHASE_W-1:0]   trigger_ff;
   logic [uer_pkg::TIMEOUT_W-1:0] timeout_ff;
   logic [DV_W-1:0]               ticks_cm_ff;
   logic [uer_pkg::DIST_W-1:0]    max_range_ff;
   logic [uer_pkg::ATTEMPT_W-1:0] retry_ff;

   // counters
   logic [uer_pkg::PHASE_W-1:0]   phase_ticks_ff, phase_ticks_in, phase_next;
   logic [TICK_BITS-1:0]          wait_ticks_ff, wait_ticks_in;
   logic [TICK_BITS:0]            wait_next;
   logic [TICK_BITS-1:0]          pulse_ticks_ff, pulse_ticks_in;
   logic [uer_pkg::ATTEMPT_W-1:0] attempts_ff, attempts_in;

   // divider
   logic                 div_active_ff, div_active_in;
   logic [CNT_W-1:0]     div_cnt_ff, div_cnt_in;
   logic [DV_W-1:0]      div_rem_ff, div_rem_in;
   logic [TICK_BITS-1:0] div_quo_ff, div_quo_in;
   logic [DV_W:0]        div_trial;
   logic                 div_ge;
   logic [uer_pkg::DIST_W-1:0] quot_sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_low_ff   <= uer_pkg::PRE_LOW_RST;
         trigger_ff   <= uer_pkg::TRIGGER_RST;
         timeout_ff   <= uer_pkg::TIMEOUT_RST;
         ticks_cm_ff  <= uer_pkg::TICKS_CM_RST;
         max_range_ff <= uer_pkg::MAX_RANGE_RST;
         retry_ff     <= uer_pkg::RETRY_RST;
      end else if (csr_we) begin
         case (csr_index)
            uer_pkg::CSR_PRE_LOW:   pre_low_ff   <= csr_wdata[uer_pkg::PHASE_W-1:0];
            uer_pkg::CSR_TRIGGER:   trigger_ff   <= csr_wdata[uer_pkg::PHASE_W-1:0];
            uer_pkg::CSR_TIMEOUT:   timeout_ff   <= csr_wdata[uer_pkg::TIMEOUT_W-1:0];
            uer_pkg::CSR_TICKS_CM:  ticks_cm_ff  <= csr_wdata[DV_W-1:0];
            uer_pkg::CSR_MAX_RANGE: max_range_ff <= csr_wdata[uer_pkg::DIST_W-1:0];
            uer_pkg::CSR_RETRY:     retry_ff     <= csr_wdata[uer_pkg::ATTEMPT_W-1:0];
            default: ;
         endcase
      end
   end

   // phase done when the next count reaches its budget; wait exceeded when it passes the budget or the counter range
   assign phase_next = phase_ticks_ff + 1'b1;
   assign wait_next  = {1'b0, wait_ticks_ff} + 1'b1;

   always_comb begin
      sts.pre_low_zero  = (pre_low_ff == '0);
      sts.pre_low_hit   = (phase_next >= pre_low_ff);
      sts.trig_hit      = (phase_next >= trigger_ff);
      sts.wait_over     = wait_next[TICK_BITS] ||
                          (CMP_W'(wait_next) > CMP_W'(timeout_ff));
      sts.attempts_zero = (attempts_ff == '0);
      sts.div_done      = div_active_ff && (div_cnt_ff == '0);
      sts.dist_over     = (quot_sat > max_range_ff);
   end

   always_comb begin
      phase_ticks_in = phase_ticks_ff;
      wait_ticks_in  = wait_ticks_ff;
      pulse_ticks_in = pulse_ticks_ff;
      attempts_in    = attempts_ff;
      if (cmd.phase_inc) phase_ticks_in = phase_next;
      if (cmd.wait_count) begin
         wait_ticks_in = wait_next[TICK_BITS] ? wait_ticks_ff : wait_next[TICK_BITS-1:0];
      end
      if (cmd.pulse_inc) pulse_ticks_in = pulse_ticks_ff + 1'b1;
      if (cmd.phase_clr) phase_ticks_in = '0;
      if (cmd.attempt_clr) begin
         phase_ticks_in = '0;
         wait_ticks_in  = '0;
         pulse_ticks_in = '0;
      end
      if (cmd.load_attempts) attempts_in = retry_ff;
      else if (cmd.dec_attempts) attempts_in = attempts_ff - 1'b1;
   end

   // restoring divider, one quotient bit a cycle
   assign div_trial = {div_rem_ff, div_quo_ff[TICK_BITS-1]};
   assign div_ge    = (div_trial >= {1'b0, ticks_cm_ff});
   assign quot_sat  = ((ticks_cm_ff == '0) || (div_quo_ff > TICK_BITS'(uer_pkg::DIST_SAT)))
                      ? uer_pkg::DIST_SAT : div_quo_ff[uer_pkg::DIST_W-1:0];

   always_comb begin
      div_active_in = div_active_ff;
      div_cnt_in    = div_cnt_ff;
      div_rem_in    = div_rem_ff;
      div_quo_in    = div_quo_ff;
      if (cmd.div_start) begin
         div_active_in = 1'b1;
         div_cnt_in    = CNT_W'(TICK_BITS);
         div_rem_in    = '0;
         div_quo_in    = pulse_ticks_ff;
      end else if (div_active_ff) begin
         if (div_cnt_ff == '0) begin
            div_active_in = 1'b0;
         end else begin
            div_cnt_in = div_cnt_ff - 1'b1;
            div_rem_in = div_ge ? DV_W'(div_trial - {1'b0, ticks_cm_ff})
                                : div_trial[DV_W-1:0];
            div_quo_in = {div_quo_ff[TICK_BITS-2:0], div_ge};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ticks_ff <= '0;
         wait_ticks_ff  <= '0;
         pulse_ticks_ff <= '0;
         attempts_ff    <= '0;
         div_active_ff  <= 1'b0;
         div_cnt_ff     <= '0;
      end else begin
         phase_ticks_ff <= phase_ticks_in;
         wait_ticks_ff  <= wait_ticks_in;
         pulse_ticks_ff <= pulse_ticks_in;
         attempts_ff    <= attempts_in;
         div_active_ff  <= div_active_in;
         div_cnt_ff     <= div_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      div_rem_ff <= div_rem_in;
      div_quo_ff <= div_quo_in;
      if (cmd.rsp_load) begin
         rsp_trig_level  <= cmd.rsp_trig;
         rsp_busy_res    <= cmd.rsp_busy;
         rsp_done_res    <= cmd.rsp_done;
         rsp_distance_cm <= cmd.rsp_use_quot ? quot_sat : '0;
         rsp_status      <= cmd.rsp_status;
      end
   end

endmodule

@@ rtl/core/uer_ctrl.sv @@
// Controller of the ultrasonic echo ranger: ranging phase state machine and
// channel handshake. Depends on uer_pkg.
`timescale 1ns / 1ps

module uer_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             start_req,
   input  logic             echo_level,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  uer_pkg::sts_type sts,
   output uer_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PRE_LOW,
      ST_TRIG_HIGH,
      ST_WAIT_RISE,
      ST_MEASURE,
      ST_DIVIDE
   } state_type;

   state_type            state_ff, state_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 accept;
   logic                 end_now;
   uer_pkg::status_type  end_status;
   state_type            attempt_state;

   assign req_ready     = (state_ff != ST_DIVIDE) && (!rsp_valid_ff || rsp_ready);
   assign accept        = req_valid && req_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign attempt_state = sts.pre_low_zero ? ST_TRIG_HIGH : ST_PRE_LOW;

   always_comb begin
      cmd        = '0;
      state_in   = state_ff;
      end_now    = 1'b0;
      end_status = uer_pkg::STAT_OK;
      cmd.rsp_status = uer_pkg::STAT_OK;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.rsp_load = 1'b1;
               if (start_req) begin
                  cmd.rsp_busy      = 1'b1;
                  cmd.load_attempts = 1'b1;
                  cmd.attempt_clr   = 1'b1;
                  state_in          = attempt_state;
               end
            end
         end
         ST_PRE_LOW: begin
            if (accept) begin
               cmd.rsp_load  = 1'b1;
               cmd.rsp_busy  = 1'b1;
               cmd.phase_inc = 1'b1;
               if (sts.pre_low_hit) begin
                  cmd.phase_clr = 1'b1;
                  state_in      = ST_TRIG_HIGH;
               end
            end
         end
         ST_TRIG_HIGH: begin
            if (accept) begin
               cmd.rsp_load  = 1'b1;
               cmd.rsp_busy  = 1'b1;
               cmd.rsp_trig  = 1'b1;
               cmd.phase_inc = 1'b1;
               if (sts.trig_hit) begin
                  cmd.attempt_clr = 1'b1;
                  state_in        = ST_WAIT_RISE;
               end
            end
         end
         ST_WAIT_RISE, ST_MEASURE: begin
            if (accept) begin
               if (echo_level) begin
                  cmd.rsp_load   = 1'b1;
                  cmd.rsp_busy   = 1'b1;
                  cmd.pulse_inc  = 1'b1;
                  cmd.wait_count = 1'b1;
                  state_in       = ST_MEASURE;
                  end_now        = sts.wait_over;
                  end_status     = uer_pkg::STAT_TIMEOUT;
               end else if (state_ff == ST_WAIT_RISE) begin
                  cmd.rsp_load   = 1'b1;
                  cmd.rsp_busy   = 1'b1;
                  cmd.wait_count = 1'b1;
                  end_now        = sts.wait_over;
                  end_status     = uer_pkg::STAT_TIMEOUT;
               end else begin
                  // echo fell: hold this tick's result until the divider finishes
                  cmd.div_start = 1'b1;
                  state_in      = ST_DIVIDE;
               end
            end
         end
         ST_DIVIDE: begin
            if (sts.div_done) begin
               cmd.rsp_load     = 1'b1;
               cmd.rsp_busy     = 1'b1;
               cmd.rsp_use_quot = 1'b1;
               end_now          = 1'b1;
               end_status       = sts.dist_over ? uer_pkg::STAT_NO_OBSTACLE
                                                : uer_pkg::STAT_OK;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (end_now) begin
         if ((end_status != uer_pkg::STAT_OK) && !sts.attempts_zero) begin
            cmd.dec_attempts = 1'b1;
            cmd.attempt_clr  = 1'b1;
            cmd.rsp_use_quot = 1'b0;
            state_in         = attempt_state;
         end else begin
            cmd.phase_clr  = 1'b1;
            cmd.rsp_busy   = 1'b0;
            cmd.rsp_done   = 1'b1;
            cmd.rsp_status = end_status;
            state_in       = ST_IDLE;
         end
      end else begin
         cmd.rsp_use_quot = 1'b0;
      end
   end

   assign rsp_valid_in = cmd.rsp_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // a new result never overwrites one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten while stalled");

   // a divider start, from an accepted falling-echo tick, enters the divide state with ticks refused
   a_div_enter: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> (state_ff == ST_DIVIDE) && !req_ready)
      else $error("divide not entered after start");

   // divider completion is only seen while waiting on it
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      sts.div_done |-> (state_ff == ST_DIVIDE))
      else $error("divider done outside divide state");

   // a final result always leaves the block idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.rsp_load && cmd.rsp_done) |=> (state_ff == ST_IDLE) && rsp_valid_ff)
      else $error("done result without return to idle");

endmodule

@@ rtl/core/ultrasonic_echo_ranger_unit.sv @@
// Top level of the ultrasonic echo ranger: binds controller, datapath and the
// channel interfaces. Depends on uer_pkg, uer_chan_if, uer_ctrl, uer_datapath.
`timescale 1ns / 1ps

// Usage
//  req_chan  : one transaction per timer tick, carrying start_req and the
//              sampled echo_level of that tick.
//  rsp_chan  : one transaction per accepted tick: trigger drive, busy, done,
//              distance in cm and status (ok, timeout, no obstacle).
//  csr_*     : register write port (index = register number), write while idle.
//  Result    : a tick's result is registered and offered the cycle after its
//              acceptance; a new tick is taken in the same cycle that the
//              previous result is taken; unstalled, the rate is one tick a cycle.
//  Exception : the tick on which the echo falls runs the serial divider, one
//              quotient bit a cycle; its result is registered once the divider
//              is done, and req_chan.ready stays low meanwhile.
//  Reset     : synchronous, active high; registers return to their defaults,
//              the sequencer goes idle and no result is pending.
//  Stall     : while rsp_chan.ready is low the waiting result is held and no
//              further tick is accepted, so no transaction is dropped.
module ultrasonic_echo_ranger_unit #(
   parameter int TICK_BITS = uer_pkg::TICK_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   uer_req_if.sink                         req_chan,
   uer_rsp_if.source                       rsp_chan,
   input  logic                            csr_we,
   input  logic [uer_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [uer_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   uer_pkg::cmd_type cmd;
   uer_pkg::sts_type sts;

   // sequencer: phases, retries and handshake
   uer_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_ready  (req_chan.ready),
      .start_req  (req_chan.start_req),
      .echo_level (req_chan.echo_level),
      .rsp_valid  (rsp_chan.valid),
      .rsp_ready  (rsp_chan.ready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // counters, registers, divider and result register
   uer_datapath #(
      .TICK_BITS (TICK_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_trig_level  (rsp_chan.trig_level),
      .rsp_busy_res    (rsp_chan.busy_res),
      .rsp_done_res    (rsp_chan.done_res),
      .rsp_distance_cm (rsp_chan.distance_cm),
      .rsp_status      (rsp_chan.status)
   );

endmodule
